/* sv/assert_macros.svh */
// Concurrent assertion helpers, clocked on the rising edge, off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/lzwd_pkg.sv */
`default_nettype none

package lzwd_pkg;

    localparam int OFFSET_W = 13;
    localparam int LENGTH_W = 5;
    localparam int BYTE_W   = 8;

    typedef struct packed {
        logic [OFFSET_W-1:0] back_offset;
        logic [LENGTH_W-1:0] match_length;
        logic [BYTE_W-1:0]   literal_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_last;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/lzwd_stream_if.sv */
`default_nettype none

interface lzwd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/lz77_window_decoder.sv */
// Channel | Dir | Payload                                   | Accepted when
// i_in    | in  | back_offset, match_length, literal_byte   | valid && ready
// o_out   | out | out_byte, is_last                         | valid && ready
//
// A triple copying L bytes (L = min(match_length, MAX_MATCH)) runs a read and a load
// state per copied byte, then the literal state: each copied byte is one history read
// and one registered load that writes it back, all through the single history RAM port.
// A literal-only triple runs only the literal state; a too-large offset drops the triple.
// Reset clears the FSM, pointers, count and output valid; the history RAM is not cleared.
// A stalled output holds the sequencer at the next load or literal.
`default_nettype none

`include "assert_macros.svh"

module lz77_window_decoder
    import lzwd_pkg::*;
#(
    parameter int WINDOW_SIZE = 4096,
    parameter int MAX_MATCH   = 18
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    lzwd_stream_if.sink      i_in,
    lzwd_stream_if.source    o_out
);

    localparam int PTR_W   = $clog2(WINDOW_SIZE);
    localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
    localparam int DIFF_W  = ((CNT_W > OFFSET_W) ? CNT_W : OFFSET_W) + 1;
    localparam int MM_W    = $clog2(MAX_MATCH + 1);
    localparam int LCMP_W  = (MM_W > LENGTH_W) ? MM_W : LENGTH_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_LIT  = 2'd3;

    logic [1:0]          r_state,  n_state;
    logic [PTR_W-1:0]    r_wp,     n_wp;
    logic [CNT_W-1:0]    r_seen,   n_seen;
    logic [LENGTH_W-1:0] r_count,  n_count;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [BYTE_W-1:0]   r_lit,    n_lit;
    logic                r_out_valid;
    t_out_item           r_out_data;
    logic [BYTE_W-1:0]   r_rdata;
    logic [BYTE_W-1:0]   r_ring [WINDOW_SIZE];

    logic                in_take;
    logic                slot_free;
    logic                push;
    logic [BYTE_W-1:0]   push_byte;
    logic [DIFF_W-1:0]   rd_diff;
    logic [PTR_W-1:0]    rd_addr;
    logic [LENGTH_W-1:0] in_count;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_take     = i_in.valid && i_in.ready;
    assign slot_free   = !r_out_valid || o_out.ready;
    assign push        = ((r_state == S_LOAD) || (r_state == S_LIT)) && slot_free;
    assign push_byte   = (r_state == S_LIT) ? r_lit : r_rdata;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign rd_diff = DIFF_W'(r_wp) - DIFF_W'(r_offset);
    assign rd_addr = rd_diff[DIFF_W-1] ? PTR_W'(rd_diff + DIFF_W'(WINDOW_SIZE))
                                       : PTR_W'(rd_diff);

    assign in_count = (LCMP_W'(i_in.data.match_length) > LCMP_W'(MAX_MATCH))
                    ? LENGTH_W'(MAX_MATCH) : i_in.data.match_length;

    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_seen   = r_seen;
        n_count  = r_count;
        n_offset = r_offset;
        n_lit    = r_lit;
        if (push) begin
            n_wp = (r_wp == PTR_W'(WINDOW_SIZE - 1)) ? '0 : r_wp + 1'b1;
            if (r_seen != CNT_W'(WINDOW_SIZE)) begin
                n_seen = r_seen + 1'b1;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_offset = i_in.data.back_offset;
                    n_lit    = i_in.data.literal_byte;
                    n_count  = in_count;
                    if (i_in.data.back_offset == '0) begin
                        n_state = S_LIT;
                    end else if (DIFF_W'(i_in.data.back_offset) <= DIFF_W'(r_seen)) begin
                        n_state = (in_count == '0) ? S_LIT : S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (push) begin
                    n_count = r_count - 1'b1;
                    n_state = (r_count == LENGTH_W'(1)) ? S_LIT : S_READ;
                end
            end
            S_LIT: begin
                if (push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_seen      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_seen  <= n_seen;
            r_count <= n_count;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset <= n_offset;
        r_lit    <= n_lit;
        if (push) begin
            r_out_data.out_byte <= push_byte;
            r_out_data.is_last  <= (r_state == S_LIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ring[r_wp] <= push_byte;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_ring[rd_addr];
        end
    end

    `ASSERT_IMPL(a_read_in_window, i_clk, i_rst_n, (r_state == S_READ),
                 (r_offset != '0) && (DIFF_W'(r_offset) <= DIFF_W'(r_seen)))
    `ASSERT_IMPL(a_copy_count, i_clk, i_rst_n,
                 (r_state == S_READ) || (r_state == S_LOAD), (r_count != '0))
    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n,
                 (r_state == S_LOAD) && r_out_valid && !o_out.ready,
                 $stable(r_wp) && (r_state == S_LOAD))
    `ASSERT_NEXT(a_literal_only, i_clk, i_rst_n,
                 in_take && (i_in.data.back_offset == '0), (r_state == S_LIT))
    `ASSERT_IMPL(a_seen_bound, i_clk, i_rst_n, 1'b1,
                 DIFF_W'(r_seen) <= DIFF_W'(WINDOW_SIZE))

endmodule

`default_nettype wire

/* sim/tb_lz77_window_decoder.sv */
`default_nettype none

module tb_lz77_window_decoder;
    import lzwd_pkg::*;

    localparam int WINDOW      = 4096;
    localparam int MATCH_CAP   = 18;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 64;
    localparam int LIMIT       = 200000;
    localparam int MAX_PRINTS  = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lzwd_stream_if #(.t_payload(t_in_item))  in_if ();
    lzwd_stream_if #(.t_payload(t_out_item)) out_if ();

    lz77_window_decoder #(
        .WINDOW_SIZE (WINDOW),
        .MAX_MATCH   (MATCH_CAP)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [7:0]  history [WINDOW];
    logic [11:0] wr_ptr = '0;
    int          seen_bytes = 0;
    t_out_item   expected_bytes [$];

    int          error_count = 0;
    int          triples_sent = 0;
    int          triples_dropped = 0;
    int          bytes_checked = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;
    int          hold_requests = 0;
    int          holds_granted = 0;
    int          rx_wait = 0;
    t_out_item   want;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("ERROR: %s", msg);
        end
    endtask

    function automatic void push_expected(input logic [7:0] b, input logic last);
        t_out_item r;
        r.out_byte = b;
        r.is_last  = last;
        expected_bytes = {expected_bytes, r};
        history[wr_ptr] = b;
        wr_ptr = wr_ptr + 12'd1;
        if (seen_bytes < WINDOW) begin
            seen_bytes++;
        end
    endfunction

    function automatic void decode_triple(input t_in_item item);
        int run;
        if (item.back_offset == '0) begin
            push_expected(item.literal_byte, 1'b1);
            return;
        end
        if (item.back_offset > seen_bytes) begin
            triples_dropped++;
            return;
        end
        run = (item.match_length > MATCH_CAP) ? MATCH_CAP : int'(item.match_length);
        for (int j = 0; j < run; j++) begin
            push_expected(history[wr_ptr - item.back_offset[11:0]], 1'b0);
        end
        push_expected(item.literal_byte, 1'b1);
    endfunction

    task automatic send_triple(input int off, input int len, input int lit);
        t_in_item item;
        int gap;
        item.back_offset  = off[OFFSET_W-1:0];
        item.match_length = len[LENGTH_W-1:0];
        item.literal_byte = lit[BYTE_W-1:0];
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= item;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        decode_triple(item);
        triples_sent++;
    endtask

    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
    endtask

    // Receiver: long hold on request, otherwise short random stalls while idle_on is set.
    always @(posedge clk) begin
        if (holds_granted != hold_requests) begin
            holds_granted++;
            rx_wait = LONG_HOLD;
        end else if (rx_wait == 0 && idle_on && $urandom_range(0, 4) == 0) begin
            rx_wait = $urandom_range(1, 3);
        end
        if (rx_wait > 0) begin
            rx_wait--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          out_if.data.out_byte, out_if.data.is_last));
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (out_if.data.out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                              bytes_checked, out_if.data.out_byte,
                                              want.out_byte));
                end
                if (out_if.data.is_last !== want.is_last) begin
                    report_mismatch($sformatf("byte %0d: is_last %0b, want %0b",
                                              bytes_checked, out_if.data.is_last,
                                              want.is_last));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still pending",
                     cycle_count, expected_bytes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic random_triple();
        int off;
        int len;
        int pick;
        pick = $urandom_range(0, 9);
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, MATCH_CAP);
        if (pick == 0 || seen_bytes == 0) begin
            off = 0;
        end else if (pick == 1) begin
            off = $urandom_range(seen_bytes + 1, 8191);
        end else if (pick <= 4) begin
            off = $urandom_range(1, (seen_bytes < 4) ? seen_bytes : 4);
        end else begin
            off = $urandom_range(1, seen_bytes);
        end
        send_triple(off, len, $urandom_range(0, 255));
    endtask

    task automatic test_directed_cases();
        send_triple(1, 5, 8'h11);
        send_triple(0, 0, 8'h00);
        send_triple(0, 31, 8'hFF);
        send_triple(1, 0, 8'hA5);
        send_triple(2, 3, 8'h5A);
        send_triple(1, MATCH_CAP, 8'h80);
        send_triple(5, 31, 8'h7F);
        send_triple(3, MATCH_CAP + 1, 8'h01);
        send_triple(seen_bytes, 16, 8'hC3);
        send_triple(seen_bytes + 1, 2, 8'h3C);
        send_triple(8191, 31, 8'hFF);
        send_triple(WINDOW, 1, 8'h55);
        send_triple(1, 1, 8'hFE);
        send_triple(seen_bytes, 8, 8'hAA);
        wait_for_drain();
    endtask

    task automatic test_random_triples(input int count);
        repeat (count) random_triple();
        wait_for_drain();
    endtask

    task automatic test_output_backpressure();
        hold_requests++;
        repeat (12) begin
            send_triple($urandom_range(1, seen_bytes), MATCH_CAP, $urandom_range(0, 255));
        end
        wait_for_drain();
    endtask

    task automatic test_far_offsets();
        send_triple(seen_bytes, MATCH_CAP, 8'h99);
        send_triple(seen_bytes - 1, 31, 8'h66);
        send_triple(seen_bytes + 1, 4, 8'h12);
        send_triple(8191, 0, 8'h34);
        send_triple(WINDOW, 0, 8'h00);
        send_triple(WINDOW, MATCH_CAP, 8'h21);
        repeat (4) begin
            send_triple($urandom_range(1, 5), MATCH_CAP, $urandom_range(0, 255));
        end
        wait_for_drain();
    endtask

    task automatic test_no_idle_tail(input int count);
        idle_on = 1'b0;
        repeat (count) random_triple();
        wait_for_drain();
    endtask

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_triples(75);
        test_output_backpressure();
        test_far_offsets();
        test_no_idle_tail(20);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
        end

        $display("Decoded %0d triples (%0d out of range) into %0d checked bytes",
                 triples_sent, triples_dropped, bytes_checked);
        $display("Covered literals, overlapping and overlong copies, far and invalid offsets");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+sv
sv/lzwd_pkg.sv
sv/lzwd_stream_if.sv
sv/lz77_window_decoder.sv
sim/tb_lz77_window_decoder.sv
